// ===== rtl/cbam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbam_pkg;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFFSET_W = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFFSET_W = $clog2(RAM_BANK_BYTES);

  localparam int unsigned ROM_BANK_W = 9;
  localparam int unsigned RAM_BANK_W = 4;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned TARGET_W = 3;
  localparam int unsigned PHYS_W = 23;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [TARGET_W-1:0] TGT_OPEN = 3'd0;
  localparam logic [TARGET_W-1:0] TGT_ROM = 3'd1;
  localparam logic [TARGET_W-1:0] TGT_RAM = 3'd2;
  localparam logic [TARGET_W-1:0] TGT_INT = 3'd3;
  localparam logic [TARGET_W-1:0] TGT_REG = 3'd4;

  localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBC5 = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_KIND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_MASK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RESET = KIND_MBC1;
  localparam logic [ROM_BANK_W-1:0] ROM_MASK_RESET = 9'h1FF;
  localparam logic [RAM_BANK_W-1:0] RAM_MASK_RESET = 4'h3;
  localparam logic [ROM_BANK_W-1:0] BANK_LOW_RESET = 9'd1;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [PHYS_W-1:0] phys_address;
    logic is_write;
    logic [DATA_W-1:0] out_data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cartridge_bank_address_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while the skid stage is empty; the
// output register and skid stage hold two entries, so one more transaction is
// accepted while a result waits on out_ready. Results are registered.
// Reset: synchronous, active high; restores the configuration registers and
// bank state to their power-on values and empties the output stages.

module cartridge_bank_address_mapper
  import cbam_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire [CFG_INDEX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]    cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     req_type,
  input  wire [ADDR_W-1:0]        bus_address,
  input  wire [DATA_W-1:0]        bus_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [TARGET_W-1:0]     target,
  output logic [PHYS_W-1:0]       phys_address,
  output logic                    is_write,
  output logic [DATA_W-1:0]       out_data
);

  logic [KIND_W-1:0] controller_kind;
  logic [ROM_BANK_W-1:0] rom_bank_limit_mask;
  logic [RAM_BANK_W-1:0] ram_bank_limit_mask;

  logic ram_enable;
  logic ram_enable_next;
  logic [ROM_BANK_W-1:0] bank_low;
  logic [ROM_BANK_W-1:0] bank_low_next;
  logic [RAM_BANK_W-1:0] bank_upper;
  logic [RAM_BANK_W-1:0] bank_upper_next;
  logic advanced_mode;
  logic advanced_mode_next;

  logic mbc1;
  logic mbc5;
  logic accept;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_page;
  result_t res;
  result_t out_reg;
  result_t skid_reg;
  logic skid_valid;

  assign mbc1 = (controller_kind == KIND_MBC1);
  assign mbc5 = (controller_kind == KIND_MBC5);
  assign in_ready = !skid_valid;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_kind <= KIND_RESET;
      rom_bank_limit_mask <= ROM_MASK_RESET;
      ram_bank_limit_mask <= RAM_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND: controller_kind <= cfg_data[KIND_W-1:0];
        CFG_ROM_MASK: rom_bank_limit_mask <= cfg_data[ROM_BANK_W-1:0];
        CFG_RAM_MASK: ram_bank_limit_mask <= cfg_data[RAM_BANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mbc1) begin
      if (bus_address[14]) begin
        rom_bank = {2'b00, bank_upper[1:0], bank_low[4:0]};
      end else if (advanced_mode) begin
        rom_bank = {2'b00, bank_upper[1:0], 5'd0};
      end else begin
        rom_bank = '0;
      end
      ram_page = advanced_mode ? {2'b00, bank_upper[1:0]} : '0;
    end else begin
      rom_bank = bank_low;
      ram_page = bank_upper;
    end
  end

  always_comb begin
    res = '0;
    ram_enable_next = ram_enable;
    bank_low_next = bank_low;
    bank_upper_next = bank_upper;
    advanced_mode_next = advanced_mode;
    if (!bus_address[15]) begin
      if (!mbc1 && !mbc5) begin
        if (req_type) begin
          res.target = TGT_OPEN;
        end else begin
          res.target = TGT_ROM;
          res.phys_address = {7'd0, bus_address};
        end
      end else if (req_type) begin
        res.target = TGT_REG;
        if (bus_address[14:13] == 2'b00) begin
          ram_enable_next = (bus_data[3:0] == RAM_EN_KEY);
        end else if (mbc1) begin
          case (bus_address[14:13])
            2'b01: begin
              bank_low_next = (bus_data[4:0] == 5'd0) ? BANK_LOW_RESET
                                                      : {4'd0, bus_data[4:0]};
            end
            2'b10: bank_upper_next = {2'b00, bus_data[1:0]};
            default: advanced_mode_next = bus_data[0];
          endcase
        end else begin
          if (bus_address[14:12] == 3'b010) begin
            bank_low_next = {bank_low[8], bus_data};
          end else if (bus_address[14:12] == 3'b011) begin
            bank_low_next = {bus_data[0], bank_low[7:0]};
          end else if (bus_address[14:13] == 2'b10) begin
            bank_upper_next = bus_data[3:0];
          end
        end
      end else begin
        res.target = TGT_ROM;
        if (mbc5 && !bus_address[14]) begin
          res.phys_address = {7'd0, bus_address};
        end else begin
          res.phys_address = {rom_bank & rom_bank_limit_mask,
                              bus_address[ROM_OFFSET_W-1:0]};
        end
      end
    end else if (bus_address inside {[16'hA000:16'hBFFF]}) begin
      if ((!mbc1 && !mbc5) || !ram_enable) begin
        res.target = TGT_OPEN;
      end else begin
        res.target = TGT_RAM;
        res.phys_address = {6'd0, ram_page & ram_bank_limit_mask,
                            bus_address[RAM_OFFSET_W-1:0]};
        res.is_write = req_type;
        res.out_data = req_type ? bus_data : '0;
      end
    end else begin
      res.target = TGT_INT;
      res.phys_address = {7'd0, bus_address};
      res.is_write = req_type;
      res.out_data = req_type ? bus_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= 1'b0;
      bank_low <= BANK_LOW_RESET;
      bank_upper <= '0;
      advanced_mode <= 1'b0;
    end else if (accept) begin
      ram_enable <= ram_enable_next;
      bank_low <= bank_low_next;
      bank_upper <= bank_upper_next;
      advanced_mode <= advanced_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign target = out_reg.target;
  assign phys_address = out_reg.phys_address;
  assign is_write = out_reg.is_write;
  assign out_data = out_reg.out_data;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid stage holds a result while the output register is empty.");

  a_no_write_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (target == TGT_OPEN || target == TGT_REG)) |-> !is_write)
    else $error("Open bus or register transaction carries a memory write.");

  a_ram_enable_key: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type && bus_address[15:13] == 3'b000 &&
     (controller_kind == KIND_MBC1 || controller_kind == KIND_MBC5) &&
     bus_data[3:0] == RAM_EN_KEY) |=> ram_enable)
    else $error("RAM enable key write did not enable cartridge RAM.");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cbam_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int ACCESSES_PER_PHASE = 100;

  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_WRITE = 1'b1;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [ADDR_W-1:0] bus_address = '0;
  logic [DATA_W-1:0] bus_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TARGET_W-1:0] target;
  logic [PHYS_W-1:0] phys_address;
  logic is_write;
  logic [DATA_W-1:0] out_data;

  cartridge_bank_address_mapper u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .bus_address(bus_address),
    .bus_data(bus_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target(target),
    .phys_address(phys_address),
    .is_write(is_write),
    .out_data(out_data)
  );

  // Mirror of the controller configuration and bank state.
  logic [KIND_W-1:0] ctrl_kind = KIND_RESET;
  logic [ROM_BANK_W-1:0] rom_mask = ROM_MASK_RESET;
  logic [RAM_BANK_W-1:0] ram_mask = RAM_MASK_RESET;
  logic ram_on = 1'b0;
  logic [ROM_BANK_W-1:0] bank_lo = BANK_LOW_RESET;
  logic [RAM_BANK_W-1:0] bank_hi = '0;
  logic wide_mode = 1'b0;

  bus_access_t access_q[$];
  result_t mapped_q[$];
  bus_access_t on_bus;
  int send_gap = 0;
  int ready_stall = 0;
  int mismatches = 0;
  int cycles = 0;
  logic steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t map_access(input bus_access_t acc);
    result_t r;
    logic [ROM_BANK_W-1:0] rb;
    logic [RAM_BANK_W-1:0] ab;
    logic banked;
    r = '0;
    banked = (ctrl_kind == KIND_MBC1) || (ctrl_kind == KIND_MBC5);
    if (!acc.addr[15]) begin
      if (!banked) begin
        if (acc.wr) begin
          r.target = TGT_OPEN;
        end else begin
          r.target = TGT_ROM;
          r.phys_address = {7'd0, acc.addr};
        end
      end else if (acc.wr) begin
        r.target = TGT_REG;
        if (acc.addr <= 16'h1FFF) begin
          ram_on = (acc.data[3:0] == RAM_EN_KEY);
        end else if (ctrl_kind == KIND_MBC1) begin
          if (acc.addr <= 16'h3FFF) begin
            bank_lo = (acc.data[4:0] == 5'd0) ? 9'd1 : {4'd0, acc.data[4:0]};
          end else if (acc.addr <= 16'h5FFF) begin
            bank_hi = {2'd0, acc.data[1:0]};
          end else begin
            wide_mode = acc.data[0];
          end
        end else begin
          if (acc.addr <= 16'h2FFF) begin
            bank_lo = {bank_lo[8], acc.data};
          end else if (acc.addr <= 16'h3FFF) begin
            bank_lo = {acc.data[0], bank_lo[7:0]};
          end else if (acc.addr <= 16'h5FFF) begin
            bank_hi = acc.data[3:0];
          end
        end
      end else begin
        r.target = TGT_ROM;
        if (ctrl_kind == KIND_MBC1) begin
          if (acc.addr[14]) begin
            rb = {2'd0, bank_hi[1:0], bank_lo[4:0]};
          end else begin
            rb = wide_mode ? {2'd0, bank_hi[1:0], 5'd0} : 9'd0;
          end
        end else begin
          rb = acc.addr[14] ? bank_lo : 9'd0;
        end
        r.phys_address = {rb & rom_mask, acc.addr[13:0]};
      end
    end else if (acc.addr[15:13] == 3'b101) begin
      if (!banked || !ram_on) begin
        r.target = TGT_OPEN;
      end else begin
        if (ctrl_kind == KIND_MBC1) begin
          ab = wide_mode ? {2'd0, bank_hi[1:0]} : 4'd0;
        end else begin
          ab = bank_hi;
        end
        r.target = TGT_RAM;
        r.phys_address = {6'd0, ab & ram_mask, acc.addr[12:0]};
        r.is_write = acc.wr;
        r.out_data = acc.wr ? acc.data : 8'd0;
      end
    end else begin
      r.target = TGT_INT;
      r.phys_address = {7'd0, acc.addr};
      r.is_write = acc.wr;
      r.out_data = acc.wr ? acc.data : 8'd0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic bus_access_t random_access();
    bus_access_t acc;
    int r;
    r = $urandom_range(0, 99);
    acc.wr = 1'($urandom_range(0, 1));
    acc.data = DATA_W'($urandom_range(0, 255));
    if (r < 30) begin
      acc.wr = REQ_WRITE;
      acc.addr = ADDR_W'($urandom_range(0, 16'h7FFF));
      if ($urandom_range(0, 2) == 0) begin
        acc.data[3:0] = RAM_EN_KEY;
      end
    end else if (r < 55) begin
      acc.wr = REQ_READ;
      acc.addr = ADDR_W'($urandom_range(0, 16'h7FFF));
    end else if (r < 80) begin
      acc.addr = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
    end else if (r < 90) begin
      acc.addr = $urandom_range(0, 1) ? ADDR_W'($urandom_range(16'h8000, 16'h9FFF))
                                      : ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
    end else begin
      acc.addr = ADDR_W'($urandom_range(0, 16'hFFFF));
    end
    return acc;
  endfunction

  task automatic push_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    access_q.push_back('{wr: wr, addr: addr, data: data});
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KIND: ctrl_kind = val[KIND_W-1:0];
      CFG_ROM_MASK: rom_mask = val[ROM_BANK_W-1:0];
      CFG_RAM_MASK: ram_mask = val[RAM_BANK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (access_q.size() != 0 || in_valid || mapped_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        mapped_q.push_back(map_access(on_bus));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (access_q.size() > 0) begin
          on_bus = access_q.pop_front();
          req_type <= on_bus.wr;
          bus_address <= on_bus.addr;
          bus_data <= on_bus.data;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual target 0x%0h",
                   $time, target);
          mismatches++;
        end else begin
          want = mapped_q.pop_front();
          check_field("target", 32'(want.target), 32'(target));
          check_field("phys_address", 32'(want.phys_address), 32'(phys_address));
          check_field("is_write", 32'(want.is_write), 32'(is_write));
          check_field("out_data", 32'(want.out_data), 32'(out_data));
        end
      end
      if (ready_stall > 0) begin
        ready_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          ready_stall = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [ROM_BANK_W-1:0] rmask;
    logic [RAM_BANK_W-1:0] amask;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Power-on configuration is an MBC1 controller.
    push_access(REQ_READ, 16'h0000, 8'hFF);
    push_access(REQ_READ, 16'h4000, 8'h00);
    push_access(REQ_WRITE, 16'h2000, 8'hE0);
    push_access(REQ_READ, 16'h7FFF, 8'h00);
    push_access(REQ_WRITE, 16'h3FFF, 8'hFF);
    push_access(REQ_READ, 16'h4000, 8'h00);
    push_access(REQ_READ, 16'hA000, 8'h00);
    push_access(REQ_WRITE, 16'h0000, 8'hFA);
    push_access(REQ_WRITE, 16'hA000, 8'hFF);
    push_access(REQ_WRITE, 16'h4000, 8'hFF);
    push_access(REQ_WRITE, 16'h6000, 8'h01);
    push_access(REQ_READ, 16'h3FFF, 8'h00);
    push_access(REQ_READ, 16'hBFFF, 8'h00);
    push_access(REQ_WRITE, 16'h7FFF, 8'hFE);
    push_access(REQ_WRITE, 16'h1FFF, 8'h00);
    push_access(REQ_READ, 16'h8000, 8'h00);
    push_access(REQ_WRITE, 16'h9FFF, 8'hFF);
    push_access(REQ_WRITE, 16'hFFFF, 8'hAA);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p == 2) || (p == 6);
      case (p)
        0: begin kind = KIND_MBC5; rmask = 9'h1FF; amask = 4'hF; end
        1: begin kind = KIND_PLAIN; rmask = 9'h000; amask = 4'h0; end
        2: begin kind = KIND_MBC1; rmask = 9'h01F; amask = 4'hF; end
        3: begin kind = KIND_SPARE; rmask = 9'h1FF; amask = 4'h3; end
        4: begin kind = KIND_MBC5; rmask = 9'h000; amask = 4'h0; end
        5: begin kind = KIND_MBC1; rmask = 9'h1FF; amask = 4'h0; end
        default: begin
          kind = KIND_W'($urandom_range(0, 3));
          rmask = ROM_BANK_W'($urandom_range(0, 511));
          amask = RAM_BANK_W'($urandom_range(0, 15));
        end
      endcase
      set_register(CFG_KIND, {7'd0, kind});
      set_register(CFG_ROM_MASK, rmask);
      set_register(CFG_RAM_MASK, {5'd0, amask});
      @(posedge clk);
      cfg_we <= 1'b0;
      if (p == 0) begin
        push_access(REQ_WRITE, 16'h2000, 8'hFF);
        push_access(REQ_WRITE, 16'h3000, 8'h01);
        push_access(REQ_READ, 16'h7FFF, 8'h00);
        push_access(REQ_WRITE, 16'h2FFF, 8'h00);
        push_access(REQ_READ, 16'h4000, 8'h00);
        push_access(REQ_WRITE, 16'h3FFF, 8'hFE);
        push_access(REQ_WRITE, 16'h5FFF, 8'hFF);
        push_access(REQ_WRITE, 16'h6000, 8'h55);
        push_access(REQ_WRITE, 16'h0000, 8'h0A);
        push_access(REQ_READ, 16'hBFFF, 8'h00);
      end
      for (int i = 0; i < ACCESSES_PER_PHASE; i++) begin
        access_q.push_back(random_access());
      end
      wait_idle();
    end

    if (mismatches == 0 && mapped_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_address_mapper.f =====
rtl/cbam_pkg.sv
rtl/cartridge_bank_address_mapper.sv
tb/testbench.sv
